// File: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared constants, codes and types of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTRY_W      = 33;
    localparam int CFG_IDX_W    = 8;

    localparam logic [31:0] RESET_BASE  = 32'h0100_0000;
    localparam logic [31:0] RESET_BYTES = 32'h0200_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = CFG_IDX_W'(1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        RES_DONE     = 2'd0,
        RES_NO_FIT   = 2'd1,
        RES_BAD_ADDR = 2'd2,
        RES_NULL     = 2'd3
    } res_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_A_WR,
        S_F_RD,
        S_F_CHK,
        S_NXT_CHK,
        S_F_WR,
        S_DN_RD,
        S_DN_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer and datapath: table walk, split, coalesce, shifts and totals
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic [31:0]                        req_bytes,
    input  wire logic [31:0]                        free_addr,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [31:0]                             alloc_addr,
    output logic [1:0]                              status,
    output logic [31:0]                             used_total,
    output logic [31:0]                             free_total,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data,
    output ffha_pkg::mem_req_t                      mem_req,
    input  wire logic [ffha_pkg::ENTRY_W-1:0]       mem_rdata
);

    localparam int CW = ffha_pkg::CNT_W;
    localparam int IW = ffha_pkg::IDX_W;
    localparam logic [31:0] HDR = 32'(ffha_pkg::HEADER_BYTES);

    ffha_pkg::state_t state_reg, state_next;

    logic [31:0]   base_reg, base_next;
    logic [31:0]   bytes_reg, bytes_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   used_reg, used_next;
    logic [31:0]   free_reg, free_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0]   off_reg, off_next;
    logic [32:0]   rnd_reg, rnd_next;
    logic [31:0]   fa_reg, fa_next;
    logic [31:0]   cur_reg, cur_next;
    logic          cur_used_reg, cur_used_next;
    logic [31:0]   prev_reg, prev_next;
    logic          prev_used_reg, prev_used_next;
    logic [31:0]   nxt_reg, nxt_next;
    logic          nm_reg, nm_next;
    logic [1:0]    d_reg, d_next;
    logic [31:0]   raddr_res_reg, raddr_res_next;
    ffha_pkg::res_t res_reg, res_next;
    logic          ov_reg, ov_next;
    logic [31:0]   oa_reg, oa_next;
    logic [1:0]    os_reg, os_next;
    logic [31:0]   ou_reg, ou_next;
    logic [31:0]   of_reg, of_next;

    logic          in_beat, cfg_beat;
    logic [32:0]   rnd_in;
    logic          rd_used;
    logic [31:0]   rd_size;
    logic          fit, split_ok, pm;
    logic [31:0]   seg_addr, init_size, merged;
    logic [CW-1:0] src_j;

    assign in_ready  = (state_reg == ffha_pkg::S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ffha_pkg::S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    assign out_valid  = ov_reg;
    assign alloc_addr = oa_reg;
    assign status     = os_reg;
    assign used_total = ou_reg;
    assign free_total = of_reg;

    assign rnd_in = (({1'b0, req_bytes} + 33'(ffha_pkg::ALIGN_BYTES - 1))
                    / ffha_pkg::ALIGN_BYTES) * ffha_pkg::ALIGN_BYTES;
    assign rd_used  = mem_rdata[32];
    assign rd_size  = mem_rdata[31:0];
    assign fit      = !rd_used && ({1'b0, rd_size} >= rnd_reg);
    assign split_ok = ({2'b00, rd_size} > ({1'b0, rnd_reg}
                      + 34'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES)))
                      && (count_reg < CW'(ffha_pkg::MAX_SEGMENTS));
    assign seg_addr  = base_reg + off_reg + HDR;
    assign init_size = (bytes_reg > HDR) ? (bytes_reg - HDR) : 32'd0;
    assign pm        = (idx_reg != '0) && !prev_used_reg;
    assign merged    = (pm ? (prev_reg + HDR) : 32'd0) + cur_reg
                       + (nm_reg ? (nxt_reg + HDR) : 32'd0);
    assign src_j     = idx_reg + CW'(1) + CW'(nm_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_INIT:     state_next = ffha_pkg::S_IDLE;
            ffha_pkg::S_IDLE:
            begin
                if (cfg_beat && (cfg_index == ffha_pkg::CFG_HEAP_BASE
                                 || cfg_index == ffha_pkg::CFG_HEAP_BYTES))
                begin
                    state_next = ffha_pkg::S_INIT;
                end
                else if (in_beat)
                begin
                    if (cmd == ffha_pkg::CMD_ALLOC)
                    begin
                        state_next = (req_bytes == 32'd0 || rnd_in[32])
                                     ? ffha_pkg::S_RESP : ffha_pkg::S_A_RD;
                    end
                    else
                    begin
                        state_next = (free_addr == 32'd0)
                                     ? ffha_pkg::S_RESP : ffha_pkg::S_F_RD;
                    end
                end
            end
            ffha_pkg::S_A_RD:     state_next = ffha_pkg::S_A_CHK;
            ffha_pkg::S_A_CHK:
            begin
                if (fit)
                begin
                    if (split_ok)
                    begin
                        state_next = (idx_reg + CW'(1) < count_reg)
                                     ? ffha_pkg::S_UP_RD : ffha_pkg::S_SPLIT_HI;
                    end
                    else
                    begin
                        state_next = ffha_pkg::S_A_WR;
                    end
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    state_next = ffha_pkg::S_RESP;
                end
                else
                begin
                    state_next = ffha_pkg::S_A_RD;
                end
            end
            ffha_pkg::S_UP_RD:    state_next = ffha_pkg::S_UP_WR;
            ffha_pkg::S_UP_WR:
            begin
                state_next = (j_reg == idx_reg + CW'(1))
                             ? ffha_pkg::S_SPLIT_HI : ffha_pkg::S_UP_RD;
            end
            ffha_pkg::S_SPLIT_HI: state_next = ffha_pkg::S_SPLIT_LO;
            ffha_pkg::S_SPLIT_LO: state_next = ffha_pkg::S_RESP;
            ffha_pkg::S_A_WR:     state_next = ffha_pkg::S_RESP;
            ffha_pkg::S_F_RD:     state_next = ffha_pkg::S_F_CHK;
            ffha_pkg::S_F_CHK:
            begin
                if (seg_addr == fa_reg)
                begin
                    state_next = (idx_reg + CW'(1) < count_reg)
                                 ? ffha_pkg::S_NXT_CHK : ffha_pkg::S_F_WR;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    state_next = ffha_pkg::S_RESP;
                end
                else
                begin
                    state_next = ffha_pkg::S_F_RD;
                end
            end
            ffha_pkg::S_NXT_CHK:  state_next = ffha_pkg::S_F_WR;
            ffha_pkg::S_F_WR:
            begin
                state_next = ((pm || nm_reg) && (src_j < count_reg))
                             ? ffha_pkg::S_DN_RD : ffha_pkg::S_RESP;
            end
            ffha_pkg::S_DN_RD:    state_next = ffha_pkg::S_DN_WR;
            ffha_pkg::S_DN_WR:
            begin
                // count already dropped by the merge distance
                state_next = (j_reg + CW'(1) == count_reg + CW'(d_reg))
                             ? ffha_pkg::S_RESP : ffha_pkg::S_DN_RD;
            end
            ffha_pkg::S_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:              state_next = ffha_pkg::S_INIT;
        endcase
    end

    // memory port
    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[IW-1:0];
        mem_req.wdata = {1'b0, cur_reg};
        mem_req.raddr = idx_reg[IW-1:0];
        unique case (state_reg)
            ffha_pkg::S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = {1'b0, init_size};
            end
            ffha_pkg::S_UP_RD,
            ffha_pkg::S_DN_RD:    mem_req.raddr = j_reg[IW-1:0];
            ffha_pkg::S_UP_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IW'(j_reg + CW'(1));
                mem_req.wdata = mem_rdata;
            end
            ffha_pkg::S_SPLIT_HI:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IW'(idx_reg + CW'(1));
                mem_req.wdata = {1'b0, cur_reg - rnd_reg[31:0] - HDR};
            end
            ffha_pkg::S_SPLIT_LO:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {1'b1, rnd_reg[31:0]};
            end
            ffha_pkg::S_A_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {1'b1, cur_reg};
            end
            ffha_pkg::S_F_CHK:    mem_req.raddr = IW'(idx_reg + CW'(1));
            ffha_pkg::S_F_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pm ? IW'(idx_reg - CW'(1)) : idx_reg[IW-1:0];
                mem_req.wdata = {1'b0, merged};
            end
            ffha_pkg::S_DN_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IW'(j_reg - CW'(d_reg));
                mem_req.wdata = mem_rdata;
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        base_next      = base_reg;
        bytes_next     = bytes_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        off_next       = off_reg;
        rnd_next       = rnd_reg;
        fa_next        = fa_reg;
        cur_next       = cur_reg;
        cur_used_next  = cur_used_reg;
        prev_next      = prev_reg;
        prev_used_next = prev_used_reg;
        nxt_next       = nxt_reg;
        nm_next        = nm_reg;
        d_next         = d_reg;
        raddr_res_next = raddr_res_reg;
        res_next       = res_reg;
        ov_next        = ov_reg && !out_ready;
        oa_next        = oa_reg;
        os_next        = os_reg;
        ou_next        = ou_reg;
        of_next        = of_reg;
        unique case (state_reg)
            ffha_pkg::S_INIT:
            begin
                count_next = CW'(1);
                used_next  = 32'd0;
                free_next  = init_size;
            end
            ffha_pkg::S_IDLE:
            begin
                if (cfg_beat)
                begin
                    if (cfg_index == ffha_pkg::CFG_HEAP_BASE)
                    begin
                        base_next = cfg_data;
                    end
                    else if (cfg_index == ffha_pkg::CFG_HEAP_BYTES)
                    begin
                        bytes_next = cfg_data;
                    end
                end
                else if (in_beat)
                begin
                    idx_next       = '0;
                    off_next       = 32'd0;
                    rnd_next       = rnd_in;
                    fa_next        = free_addr;
                    prev_used_next = 1'b1;
                    nm_next        = 1'b0;
                    raddr_res_next = 32'd0;
                    if (cmd == ffha_pkg::CMD_ALLOC)
                    begin
                        res_next = ffha_pkg::RES_NO_FIT;
                    end
                    else
                    begin
                        res_next = (free_addr == 32'd0)
                                   ? ffha_pkg::RES_NULL : ffha_pkg::RES_BAD_ADDR;
                    end
                end
            end
            ffha_pkg::S_A_CHK:
            begin
                if (fit)
                begin
                    cur_next       = rd_size;
                    raddr_res_next = seg_addr;
                    res_next       = ffha_pkg::RES_DONE;
                    j_next         = count_reg - CW'(1);
                end
                else
                begin
                    off_next = off_reg + HDR + rd_size;
                    idx_next = idx_reg + CW'(1);
                end
            end
            ffha_pkg::S_UP_WR:    j_next = j_reg - CW'(1);
            ffha_pkg::S_SPLIT_HI: count_next = count_reg + CW'(1);
            ffha_pkg::S_SPLIT_LO:
            begin
                used_next = used_reg + rnd_reg[31:0];
                free_next = free_reg - rnd_reg[31:0] - HDR;
            end
            ffha_pkg::S_A_WR:
            begin
                used_next = used_reg + cur_reg;
                free_next = free_reg - cur_reg;
            end
            ffha_pkg::S_F_CHK:
            begin
                if (seg_addr == fa_reg)
                begin
                    cur_next      = rd_size;
                    cur_used_next = rd_used;
                    res_next      = ffha_pkg::RES_DONE;
                end
                else
                begin
                    prev_next      = rd_size;
                    prev_used_next = rd_used;
                    off_next       = off_reg + HDR + rd_size;
                    idx_next       = idx_reg + CW'(1);
                end
            end
            ffha_pkg::S_NXT_CHK:
            begin
                nxt_next = rd_size;
                nm_next  = !rd_used;
            end
            ffha_pkg::S_F_WR:
            begin
                d_next     = {1'b0, pm} + {1'b0, nm_reg};
                j_next     = src_j;
                count_next = count_reg - CW'(pm) - CW'(nm_reg);
                if (cur_used_reg)
                begin
                    used_next = used_reg - cur_reg;
                end
                free_next = free_reg + (cur_used_reg ? cur_reg : 32'd0)
                            + (pm ? HDR : 32'd0) + (nm_reg ? HDR : 32'd0);
            end
            ffha_pkg::S_DN_WR:    j_next = j_reg + CW'(1);
            ffha_pkg::S_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    oa_next = raddr_res_reg;
                    os_next = res_reg;
                    ou_next = used_reg;
                    of_next = free_reg;
                end
            end
            default:
            begin
                j_next = j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_INIT;
            base_reg  <= ffha_pkg::RESET_BASE;
            bytes_reg <= ffha_pkg::RESET_BYTES;
            count_reg <= CW'(1);
            used_reg  <= 32'd0;
            free_reg  <= 32'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            bytes_reg <= bytes_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        off_reg       <= off_next;
        rnd_reg       <= rnd_next;
        fa_reg        <= fa_next;
        cur_reg       <= cur_next;
        cur_used_reg  <= cur_used_next;
        prev_reg      <= prev_next;
        prev_used_reg <= prev_used_next;
        nxt_reg       <= nxt_next;
        nm_reg        <= nm_next;
        d_reg         <= d_next;
        raddr_res_reg <= raddr_res_next;
        res_reg       <= res_next;
        oa_reg        <= oa_next;
        os_reg        <= os_next;
        ou_reg        <= ou_next;
        of_reg        <= of_next;
    end

endmodule

`default_nettype wire

// File: src/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first-fit heap allocator over an address-ordered segment table in ram
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): cmd, req_bytes, free_addr, one beat per
// request. output channel (out_valid/out_ready): alloc_addr, status,
// used_total, free_total, one beat per request.
// config channel (cfg_valid/cfg_ready): cfg_index 0 heap_base, 1 heap_bytes;
// a write to either rebuilds the table, other indexes ignored.
// one request at a time: the segment table sits in a single ram with a
// registered read, so each table read needs a read state before its use.
// allocate: walk the segments (read, check), then write a whole segment,
// or move the entries above it up (read, write) and split it in two, then
// post the result. free: walk the segments, look at the next segment,
// write, move the entries down on a merge, then post the result.
// zero size, overflow and null free go straight to the result state.
// a finished result sits in the output register; a new request is taken
// while it waits, and the next result holds until the receiver takes it.
// reset loads the default heap region and writes entry zero in the init
// state before any beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           cmd,
    input  wire logic [31:0]                    req_bytes,
    input  wire logic [31:0]                    free_addr,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [31:0]                         alloc_addr,
    output logic [1:0]                          status,
    output logic [31:0]                         used_total,
    output logic [31:0]                         free_total,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    ffha_pkg::mem_req_t               mem_req;
    logic [ffha_pkg::ENTRY_W-1:0]     mem_rdata;

    ffha_ram #(
        .WIDTH (ffha_pkg::ENTRY_W),
        .DEPTH (ffha_pkg::MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    ffha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .req_bytes  (req_bytes),
        .free_addr  (free_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .alloc_addr (alloc_addr),
        .status     (status),
        .used_total (used_total),
        .free_total (free_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

endmodule

`default_nettype wire
